/* rtl/blp_pkg.sv */
package blp_pkg;

  // request opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // per-axis step direction, minus is the two's complement of one
  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_PLUS  = 2'd1,
    DIR_MINUS = 2'd3
  } dir_t;

  localparam int COLOR_BITS = 16;

endpackage

/* rtl/blp_if.sv */
interface blp_req_if #(
  parameter int COORD_BITS = 8
);
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;
  logic [15:0]           color;

  modport source (output valid, op, start_x, start_y, end_x, end_y, color, input ready);
  modport sink (input valid, op, start_x, start_y, end_x, end_y, color, output ready);
endinterface

interface blp_pix_if #(
  parameter int COORD_BITS = 8
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [15:0]           pixel_color;
  logic                  last;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last, input ready);
  modport sink (input valid, pixel_x, pixel_y, pixel_color, last, output ready);
endinterface

/* rtl/blp_axis_setup.sv */
module blp_axis_setup #(
  parameter int COORD_BITS = 8
) (
  input  logic [COORD_BITS-1:0] from_pos,
  input  logic [COORD_BITS-1:0] to_pos,
  output blp_pkg::dir_t         dir,
  output logic [COORD_BITS-1:0] mag
);
  import blp_pkg::*;

  always_comb begin
    if (to_pos > from_pos) begin
      dir = DIR_PLUS;
      mag = to_pos - from_pos;
    end else if (to_pos == from_pos) begin
      dir = DIR_NONE;
      mag = '0;
    end else begin
      dir = DIR_MINUS;
      mag = from_pos - to_pos;
    end
  end

endmodule

/* rtl/blp_axis_step.sv */
module blp_axis_step #(
  parameter int COORD_BITS = 8
) (
  input  logic [COORD_BITS-1:0] pos,
  input  logic [COORD_BITS:0]   err,
  input  logic [COORD_BITS-1:0] mag,
  input  logic [COORD_BITS-1:0] major,
  input  blp_pkg::dir_t         dir,
  output logic [COORD_BITS-1:0] pos_next,
  output logic [COORD_BITS:0]   err_next
);
  import blp_pkg::*;

  logic [COORD_BITS:0]   err_sum;
  logic [COORD_BITS:0]   major_ext;
  logic [COORD_BITS-1:0] pos_moved;

  assign err_sum   = err + {1'b0, mag};
  assign major_ext = {1'b0, major};

  always_comb begin
    case (dir)
      DIR_PLUS:  pos_moved = pos + COORD_BITS'(1);
      DIR_MINUS: pos_moved = pos - COORD_BITS'(1);
      default:   pos_moved = pos;
    endcase
  end

  // overflowing accumulator wraps back and moves the axis
  always_comb begin
    if (err_sum > major_ext) begin
      err_next = err_sum - major_ext;
      pos_next = pos_moved;
    end else begin
      err_next = err_sum;
      pos_next = pos;
    end
  end

endmodule

/* rtl/bresenham_line_pixel_generator_core.sv */
// channel  modport          payload                                   role
// req      blp_req_if.sink  op, start_x, start_y, end_x, end_y, color  start or step request
// pix      blp_pix_if.source pixel_x, pixel_y, pixel_color, last       one pixel per live-line step
//
// one request per cycle while req.ready is high; a step request's pixel is in the output
// register the cycle after it is accepted, taken straight from the line state, while
// the single error add-compare on each axis advances the line state on the same accept
// rst is synchronous, active high, and leaves the block idle with no pixel
// req.ready drops only while an unread pixel sits in the output register
// and pix.ready is low; a start request never yields a pixel
module bresenham_line_pixel_generator_core #(
  parameter int COORD_BITS = 8
) (
  input logic           clk,
  input logic           rst,
  blp_req_if.sink       req,
  blp_pix_if.source     pix
);
  import blp_pkg::*;

  localparam int ERR_BITS = COORD_BITS + 1;

  // line state
  logic [COORD_BITS-1:0] cur_col;
  logic [COORD_BITS-1:0] cur_row;
  logic [ERR_BITS-1:0]   col_error;
  logic [ERR_BITS-1:0]   row_error;
  logic [COORD_BITS-1:0] abs_dx;
  logic [COORD_BITS-1:0] abs_dy;
  logic [COORD_BITS-1:0] major_dist;
  dir_t                  col_dir;
  dir_t                  row_dir;
  logic [ERR_BITS-1:0]   pixels_left;
  logic [COLOR_BITS-1:0] line_color;
  logic                  busy;

  // output register
  logic                  out_valid;
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;
  logic [COLOR_BITS-1:0] out_color;
  logic                  out_last;

  // setup results for a start request
  dir_t                  set_col_dir;
  dir_t                  set_row_dir;
  logic [COORD_BITS-1:0] set_dx;
  logic [COORD_BITS-1:0] set_dy;
  logic [COORD_BITS-1:0] set_major;

  // step results
  logic [COORD_BITS-1:0] cur_col_next;
  logic [COORD_BITS-1:0] cur_row_next;
  logic [ERR_BITS-1:0]   col_error_next;
  logic [ERR_BITS-1:0]   row_error_next;
  logic [ERR_BITS-1:0]   pixels_left_next;

  logic take;
  logic emit;

  // output register frees up when empty or being drained
  assign req.ready = !out_valid || pix.ready;
  assign take      = req.valid && req.ready;
  // step on a live line loads a pixel
  assign emit      = take && (req.op == OP_STEP) && busy;

  assign pix.valid       = out_valid;
  assign pix.pixel_x     = out_x;
  assign pix.pixel_y     = out_y;
  assign pix.pixel_color = out_color;
  assign pix.last        = out_last;

  blp_axis_setup #(.COORD_BITS(COORD_BITS)) u_setup_col (
    .from_pos (req.start_x),
    .to_pos   (req.end_x),
    .dir      (set_col_dir),
    .mag      (set_dx)
  );

  blp_axis_setup #(.COORD_BITS(COORD_BITS)) u_setup_row (
    .from_pos (req.start_y),
    .to_pos   (req.end_y),
    .dir      (set_row_dir),
    .mag      (set_dy)
  );

  assign set_major = (set_dx > set_dy) ? set_dx : set_dy;

  blp_axis_step #(.COORD_BITS(COORD_BITS)) u_step_col (
    .pos      (cur_col),
    .err      (col_error),
    .mag      (abs_dx),
    .major    (major_dist),
    .dir      (col_dir),
    .pos_next (cur_col_next),
    .err_next (col_error_next)
  );

  blp_axis_step #(.COORD_BITS(COORD_BITS)) u_step_row (
    .pos      (cur_row),
    .err      (row_error),
    .mag      (abs_dy),
    .major    (major_dist),
    .dir      (row_dir),
    .pos_next (cur_row_next),
    .err_next (row_error_next)
  );

  // count saturates at zero
  assign pixels_left_next = (pixels_left != '0) ? pixels_left - ERR_BITS'(1) : pixels_left;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col     <= '0;
      cur_row     <= '0;
      col_error   <= '0;
      row_error   <= '0;
      abs_dx      <= '0;
      abs_dy      <= '0;
      major_dist  <= '0;
      col_dir     <= DIR_NONE;
      row_dir     <= DIR_NONE;
      pixels_left <= '0;
      line_color  <= '0;
      busy        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pix.ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        if (req.op == OP_START) begin
          // new line replaces any line in flight
          cur_col     <= req.start_x;
          cur_row     <= req.start_y;
          col_error   <= '0;
          row_error   <= '0;
          abs_dx      <= set_dx;
          abs_dy      <= set_dy;
          major_dist  <= set_major;
          col_dir     <= set_col_dir;
          row_dir     <= set_row_dir;
          pixels_left <= ERR_BITS'(set_major) + ERR_BITS'(2);
          line_color  <= req.color;
          busy        <= 1'b1;
        end else if (busy) begin
          // emit the current pixel, then advance
          out_x       <= cur_col;
          out_y       <= cur_row;
          out_color   <= line_color;
          out_last    <= (pixels_left == ERR_BITS'(1));
          cur_col     <= cur_col_next;
          cur_row     <= cur_row_next;
          col_error   <= col_error_next;
          row_error   <= row_error_next;
          pixels_left <= pixels_left_next;
          busy        <= (pixels_left_next != '0);
        end
      end
    end
  end

  // accumulators never pass the major distance
  a_col_err_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, major_dist} >= col_error)
    else $error("column error above major distance");

  a_row_err_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, major_dist} >= row_error)
    else $error("row error above major distance");

  a_busy_count: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pixels_left != '0))
    else $error("busy with no pixels left");

  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    (take && req.op == OP_STEP && busy && pixels_left == ERR_BITS'(1)) |=> (!busy && out_last))
    else $error("line did not end on last pixel");

  a_idle_step_silent: assert property (@(posedge clk) disable iff (rst)
    (take && req.op == OP_STEP && !busy && !(out_valid && !pix.ready)) |=> !out_valid)
    else $error("pixel emitted while idle");

endmodule

/* bench/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import blp_pkg::*;

  localparam int COORD_BITS = 8;
  localparam int CYCLE_LIMIT = 600000;
  // extra cycles after the drain so a stray pixel would still be seen
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES = 300;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COLOR_BITS-1:0] color_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    color_t color;
    logic   last;
  } pixel_t;

  // line predictor and the queue of pixels it still owes
  class pixel_scoreboard;
    coord_t                cur_col;
    coord_t                cur_row;
    logic [COORD_BITS:0]   col_err;
    logic [COORD_BITS:0]   row_err;
    coord_t                abs_dx;
    coord_t                abs_dy;
    coord_t                major;
    dir_t                  col_dir;
    dir_t                  row_dir;
    logic [COORD_BITS:0]   pixels_left;
    color_t                line_color;
    bit                    busy;
    pixel_t                owed_pixels[$];
    int                    errors;
    int                    pixels_checked;
    int                    lines_started;

    function new();
      cur_col = '0;
      cur_row = '0;
      col_err = '0;
      row_err = '0;
      abs_dx = '0;
      abs_dy = '0;
      major = '0;
      col_dir = DIR_NONE;
      row_dir = DIR_NONE;
      pixels_left = '0;
      line_color = '0;
      busy = 0;
      errors = 0;
      pixels_checked = 0;
      lines_started = 0;
    endfunction

    function int pending();
      return owed_pixels.size();
    endfunction

    function void axis_setup(input coord_t from, input coord_t to,
                             output dir_t dir, output coord_t mag);
      if (to > from) begin
        dir = DIR_PLUS;
        mag = to - from;
      end else if (to == from) begin
        dir = DIR_NONE;
        mag = '0;
      end else begin
        dir = DIR_MINUS;
        mag = from - to;
      end
    endfunction

    function coord_t move_axis(coord_t pos, dir_t dir);
      if (dir == DIR_PLUS) return pos + 1'b1;
      if (dir == DIR_MINUS) return pos - 1'b1;
      return pos;
    endfunction

    // returns 1 when the block acts on the request
    function bit note_request(logic op, coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                              color_t col);
      pixel_t px;
      if (op == OP_START) begin
        axis_setup(sx, ex, col_dir, abs_dx);
        axis_setup(sy, ey, row_dir, abs_dy);
        major = (abs_dx > abs_dy) ? abs_dx : abs_dy;
        cur_col = sx;
        cur_row = sy;
        col_err = '0;
        row_err = '0;
        pixels_left = {1'b0, major} + 2'd2;
        line_color = col;
        busy = 1;
        lines_started++;
        return 1;
      end
      if (!busy) return 0;
      px.x = cur_col;
      px.y = cur_row;
      px.color = line_color;
      px.last = (pixels_left == 1);
      owed_pixels.push_back(px);
      col_err = col_err + {1'b0, abs_dx};
      row_err = row_err + {1'b0, abs_dy};
      if (col_err > {1'b0, major}) begin
        col_err = col_err - {1'b0, major};
        cur_col = move_axis(cur_col, col_dir);
      end
      if (row_err > {1'b0, major}) begin
        row_err = row_err - {1'b0, major};
        cur_row = move_axis(cur_row, row_dir);
      end
      if (pixels_left > 0) pixels_left--;
      if (pixels_left == 0) busy = 0;
      return 1;
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (owed_pixels.size() == 0) begin
        $error("unexpected pixel x=%0d y=%0d color=%h last=%0b",
               got.x, got.y, got.color, got.last);
        errors++;
        return;
      end
      want = owed_pixels.pop_front();
      pixels_checked++;
      if (got.x !== want.x) begin
        $error("pixel_x: expected %0d, actual %0d", want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $error("pixel_y: expected %0d, actual %0d", want.y, got.y);
        errors++;
      end
      if (got.color !== want.color) begin
        $error("pixel_color: expected %h, actual %h", want.color, got.color);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  blp_req_if #(.COORD_BITS(COORD_BITS)) req_ch ();
  blp_pix_if #(.COORD_BITS(COORD_BITS)) pix_ch ();

  bresenham_line_pixel_generator_core #(
    .COORD_BITS(COORD_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .pix(pix_ch)
  );

  pixel_scoreboard sb;

  // idle percentages of the two sides, changed per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // requests the block acted on: starts plus steps of a live line
  int acted_requests = 0;
  int cycle_count = 0;
  // set by the stimulus, picked up by the pixel sink process
  bit hold_request = 0;

  always #1 clk = ~clk;

  // watchdog, the run never gets near this when the block works
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // pixel sink: random back-pressure, plus one long hold-off when asked
  initial begin
    int hold_left;
    hold_left = 0;
    pix_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pix_ch.ready <= 1'b0;
      end else begin
        pix_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // sampled mid-cycle so the handshake seen is the one the next edge takes
  always @(negedge clk) begin
    pixel_t got;
    if (!rst && pix_ch.valid && pix_ch.ready) begin
      got.x = pix_ch.pixel_x;
      got.y = pix_ch.pixel_y;
      got.color = pix_ch.pixel_color;
      got.last = pix_ch.last;
      sb.check_pixel(got);
    end
  end

  // one request; called right after a rising edge, returns right after one.
  // valid is only lowered while idling, so back-to-back requests keep it high
  task automatic send_request(logic op, coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                              color_t col);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op <= op;
    req_ch.start_x <= sx;
    req_ch.start_y <= sy;
    req_ch.end_x <= ex;
    req_ch.end_y <= ey;
    req_ch.color <= col;
    taken = 0;
    while (!taken) begin
      @(negedge clk);
      taken = req_ch.ready;
      if (taken && sb.note_request(op, sx, sy, ex, ey, col)) acted_requests++;
      @(posedge clk);
    end
  endtask

  // step payload is don't-care, so it carries random bits
  task automatic send_step();
    send_request(OP_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                 coord_t'($urandom), color_t'($urandom));
  endtask

  task automatic send_steps(int n);
    repeat (n) send_step();
  endtask

  // drop valid and wait until every owed pixel is out
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // mostly short well-formed lines, now and then a long one, an abandoned
  // one, or stray steps after the end
  task automatic random_line();
    int sx, sy, ex, ey, dx, dy, span, n, roll;
    sx = $urandom_range(255);
    sy = $urandom_range(255);
    if ($urandom_range(39) == 0) begin
      ex = $urandom_range(255);
      ey = $urandom_range(255);
    end else begin
      ex = sx + $urandom_range(30) - 15;
      ey = sy + $urandom_range(30) - 15;
      if (ex < 0) ex = 0;
      if (ex > 255) ex = 255;
      if (ey < 0) ey = 0;
      if (ey > 255) ey = 255;
    end
    dx = (ex > sx) ? ex - sx : sx - ex;
    dy = (ey > sy) ? ey - sy : sy - ey;
    span = (dx > dy) ? dx : dy;
    n = span + 2;
    roll = $urandom_range(99);
    if (roll < 8) n = $urandom_range(span + 1);
    else if (roll < 16) n = n + $urandom_range(2, 1);
    send_request(OP_START, coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey),
                 color_t'($urandom));
    send_steps(n);
  endtask

  task automatic random_phase(int sender_pct, int receiver_pct, int count, bit with_hold);
    int target;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    target = acted_requests + count;
    if (with_hold) hold_request = 1;
    while (acted_requests < target) random_line();
    // sender sits still until every pixel is out
    wait_drained();
  endtask

  initial begin
    sb = new();
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.op <= OP_START;
    req_ch.start_x <= '0;
    req_ch.start_y <= '0;
    req_ch.end_x <= '0;
    req_ch.end_y <= '0;
    req_ch.color <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    send_idle_pct = 20;
    recv_idle_pct = 30;
    // step with no line running
    send_step();
    // zero-length lines at both corners, start point comes out twice
    send_request(OP_START, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000);
    send_steps(2);
    send_request(OP_START, 8'd255, 8'd255, 8'd255, 8'd255, 16'hffff);
    send_steps(2);
    // line dropped half way by a new start
    send_request(OP_START, 8'd0, 8'd255, 8'd3, 8'd250, 16'h1234);
    send_steps(3);
    // x falling, y rising, run to the end
    send_request(OP_START, 8'd255, 8'd0, 8'd252, 8'd2, 16'ha5a5);
    send_steps(5);
    // stray step after the last pixel
    send_step();
    // vertical line, x axis still
    send_request(OP_START, 8'd10, 8'd20, 8'd10, 8'd24, 16'h5a5a);
    send_steps(6);
    wait_drained();

    // random part, one long sink stall in each of the idling phases
    random_phase(17, 64, 480, 1);
    random_phase(64, 17, 480, 1);
    random_phase(0, 0, 480, 0);

    req_ch.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d lines, %0d requests acted on, %0d pixels checked",
             sb.lines_started, acted_requests, sb.pixels_checked);
    $display("idle steps, abandoned lines, zero-length and full-span lines, sink stalls");
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/blp_pkg.sv
rtl/blp_if.sv
rtl/blp_axis_setup.sv
rtl/blp_axis_step.sv
rtl/bresenham_line_pixel_generator_core.sv
bench/tb.sv
